>>> rtl/core/assert_macros.svh
// assertion macros shared by the closure engine rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic check on a named clock and active-low reset
`define ACE_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check on the house clock and reset names
`define ACE_ASSERT_CLK(name, prop, msg) `ACE_ASSERT(name, i_clk, i_rst_n, prop, msg)

`endif

>>> rtl/core/ace_pkg.sv
// shared types and constants for the attribute closure engine
// no dependencies; used by the interfaces and every module
package ace_pkg;

    // sizing
    localparam int ATTRS    = 32;
    localparam int MAX_FDS  = 16;
    localparam int MASK_W   = 32;
    localparam int ENTRY_W  = 4;
    localparam int FDC_W    = 5;
    localparam int IDX_W    = (MAX_FDS > 1) ? $clog2(MAX_FDS) : 1;
    localparam int CNT_NEED = $clog2(MAX_FDS + 1);
    localparam int USE_W    = (CNT_NEED > FDC_W) ? CNT_NEED : FDC_W;
    localparam int CMP_W    = ENTRY_W + USE_W + 1;

    // attributes at and above ATTRS are dropped
    localparam logic [MASK_W-1:0] ATTR_MASK =
        (ATTRS >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((64'd1 << ATTRS) - 64'd1);

    // item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_PASS,
        S_DONE
    } t_state;

    // table write request
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  addr;
        logic [MASK_W-1:0] left_mask;
        logic [MASK_W-1:0] right_mask;
    } t_fd_wr;

    // one dependency read back from the table
    typedef struct packed {
        logic [MASK_W-1:0] left_mask;
        logic [MASK_W-1:0] right_mask;
    } t_fd_entry;

    // result of one merge step
    typedef struct packed {
        logic [MASK_W-1:0] set;
        logic              grew;
    } t_merge;

endpackage

>>> rtl/core/ace_if.sv
// valid/ready channel interfaces for the closure engine
// depends on ace_pkg for field widths
interface ace_in_if;
    import ace_pkg::*;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [ENTRY_W-1:0] entry_index;
    logic [MASK_W-1:0]  left_mask;
    logic [MASK_W-1:0]  right_mask;
    logic [MASK_W-1:0]  start_mask;

    modport source (
        output valid, kind, entry_index, left_mask, right_mask, start_mask,
        input  ready
    );
    modport sink (
        input  valid, kind, entry_index, left_mask, right_mask, start_mask,
        output ready
    );
endinterface

interface ace_out_if;
    import ace_pkg::*;
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] closure_mask;

    modport source (
        output valid, closure_mask,
        input  ready
    );
    modport sink (
        input  valid, closure_mask,
        output ready
    );
endinterface

>>> rtl/core/ace_fd_mem.sv
// dependency table: left and right masks, one write and one registered read port
// depends on ace_pkg
module ace_fd_mem (
    input  logic                      i_clk,
    input  ace_pkg::t_fd_wr           i_wr,
    input  logic [ace_pkg::IDX_W-1:0] i_rd_addr,
    output ace_pkg::t_fd_entry        o_rd_data
);
    import ace_pkg::*;

    logic [MASK_W-1:0] r_left  [MAX_FDS];
    logic [MASK_W-1:0] r_right [MAX_FDS];
    t_fd_entry         r_rd;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_left[i_wr.addr]  <= i_wr.left_mask;
            r_right[i_wr.addr] <= i_wr.right_mask;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd.left_mask  <= r_left[i_rd_addr];
        r_rd.right_mask <= r_right[i_rd_addr];
    end

    assign o_rd_data = r_rd;

endmodule

>>> rtl/core/ace_merge.sv
// shared merge unit: subset test of one left mask and or-in of its right mask
// depends on ace_pkg
module ace_merge (
    input  logic [ace_pkg::MASK_W-1:0] i_set,
    input  ace_pkg::t_fd_entry         i_entry,
    output ace_pkg::t_merge            o_merge
);
    import ace_pkg::*;

    logic              subset;
    logic [MASK_W-1:0] next_set;

    // left side fully inside the current set fires the dependency
    always_comb begin
        subset       = ((i_entry.left_mask & ~i_set) == '0);
        next_set     = subset ? (i_set | i_entry.right_mask) : i_set;
        o_merge.set  = next_set;
        o_merge.grew = (next_set != i_set);
    end

endmodule

>>> rtl/core/ace_seq.sv
// sequencer: takes words, drives table writes, walks passes through the merge unit
// depends on ace_pkg, ace_if, ace_merge and assert_macros.svh
`include "assert_macros.svh"

module ace_seq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [ace_pkg::FDC_W-1:0] i_fd_count,
    ace_in_if.sink                    i_in,
    ace_out_if.source                 o_out,
    output ace_pkg::t_fd_wr           o_wr,
    output logic [ace_pkg::IDX_W-1:0] o_rd_addr,
    input  ace_pkg::t_fd_entry        i_rd_data
);
    import ace_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [IDX_W-1:0]  r_idx;
    logic [USE_W-1:0]  r_used;
    logic [MASK_W-1:0] r_set;
    logic              r_grew;
    logic              r_out_valid;
    logic [MASK_W-1:0] r_out_data;

    logic              accept;
    logic              is_query;
    logic              last;
    logic              grew_any;
    logic              load_out;
    logic [USE_W-1:0]  used_now;
    t_merge            merge;

    // shared merge unit
    ace_merge u_merge (
        .i_set   (r_set),
        .i_entry (i_rd_data),
        .o_merge (merge)
    );

    // handshake and pass bookkeeping
    always_comb begin
        accept   = i_in.valid && i_in.ready;
        is_query = (i_in.kind == KIND_QUERY);
        used_now = (USE_W'(i_fd_count) > USE_W'(MAX_FDS)) ? USE_W'(MAX_FDS)
                                                           : USE_W'(i_fd_count);
        last     = ((USE_W'(r_idx) + USE_W'(1)) == r_used);
        grew_any = r_grew || merge.grew;
        load_out = !r_out_valid || o_out.ready;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && is_query) begin
                    n_state = (used_now == '0) ? S_DONE : S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_PASS;
            end
            S_PASS: begin
                if (last && !grew_any) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        i_in.ready      = 1'b0;
        o_rd_addr       = '0;
        o_wr.we         = 1'b0;
        o_wr.addr       = IDX_W'(i_in.entry_index);
        o_wr.left_mask  = i_in.left_mask & ATTR_MASK;
        o_wr.right_mask = i_in.right_mask & ATTR_MASK;
        case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                o_wr.we    = accept && (i_in.kind == KIND_LOAD) &&
                             (CMP_W'(i_in.entry_index) < CMP_W'(MAX_FDS));
            end
            S_PASS: begin
                // next entry, or entry zero for a new pass
                if (!last) begin
                    o_rd_addr = r_idx + IDX_W'(1);
                end
            end
            default: begin
                o_rd_addr = '0;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // closure datapath
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && accept && is_query) begin
            r_set  <= i_in.start_mask & ATTR_MASK;
            r_used <= used_now;
            r_idx  <= '0;
            r_grew <= 1'b0;
        end else if (r_state == S_PASS) begin
            r_set <= merge.set;
            if (last) begin
                r_idx  <= '0;
                r_grew <= 1'b0;
            end else begin
                r_idx  <= r_idx + IDX_W'(1);
                r_grew <= grew_any;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && load_out) begin
            r_out_data <= r_set;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.closure_mask = r_out_data;

    // checks
    `ACE_ASSERT_CLK(a_idx_in_range, (r_state == S_PASS) |-> (USE_W'(r_idx) < r_used), "pass index beyond table entries in use")
    `ACE_ASSERT_CLK(a_set_monotonic, (r_state == S_PASS) |=> ((r_set & $past(r_set)) == $past(r_set)), "closure set lost attributes")
    `ACE_ASSERT_CLK(a_done_loads_out, (r_state == S_DONE && load_out) |=> (r_out_valid && r_state == S_IDLE), "finished closure not presented")

endmodule

>>> rtl/core/attribute_closure_engine_core.sv
// attribute closure engine top level: config register, dependency table, sequencer
// depends on ace_pkg, ace_if, ace_fd_mem, ace_seq
//
// usage
//   i_in carries one word per item: kind 0 loads left/right masks into table
//   slot entry_index, kind 1 asks for the closure of start_mask. o_out returns
//   one closure_mask word per query and nothing for a load.
//   i_cfg_we/i_cfg_data set fd_count, the number of table entries in use
//   (values above 16 act as 16); write it only while the engine is idle.
// timing
//   a load is written into the table as it is accepted. a query with n entries in
//   use runs a fetch step, then passes over the n entries until a pass adds nothing
//   (straight to done when n is 0); the merge unit checks one table entry per cycle,
//   so the table read port sets the pace. there are at most n + 1 passes.
//   the engine takes the next word once the closure sits in the output register.
// reset and stall
//   reset clears fd_count to 0, the sequencer to idle and the output valid;
//   table contents are kept and must be loaded before use. a stalled receiver
//   holds the result in the output register; a second finished query waits
//   until that word is taken.
module attribute_closure_engine_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [ace_pkg::FDC_W-1:0] i_cfg_data,
    ace_in_if.sink                    i_in,
    ace_out_if.source                 o_out
);
    import ace_pkg::*;

    logic [FDC_W-1:0] r_fd_count;
    t_fd_wr           fd_wr;
    logic [IDX_W-1:0] rd_addr;
    t_fd_entry        rd_data;

    // fd_count configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fd_count <= '0;
        end else if (i_cfg_we) begin
            r_fd_count <= i_cfg_data;
        end
    end

    // dependency table
    ace_fd_mem u_fd_mem (
        .i_clk     (i_clk),
        .i_wr      (fd_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // control and closure sequencer
    ace_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fd_count (r_fd_count),
        .i_in       (i_in),
        .o_out      (o_out),
        .o_wr       (fd_wr),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data)
    );

endmodule

>>> dv/tb_attribute_closure_engine_core.sv
`timescale 1ns / 100ps
// self-checking testbench for attribute_closure_engine_core: loads dependency words,
// queries closures and checks each closure_mask against an in-bench predictor
// depends on ace_pkg, ace_if and the rtl of the closure engine
module tb_attribute_closure_engine_core;
    import ace_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 6;
    localparam int SETTLE_CYCLES   = 300;
    localparam int HOLD_OFF_CYCLES = 1500;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int MAX_REPORTS     = 10;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_WORDS     = 135;
    localparam int POOL_SIZE       = 8;

    typedef enum logic [1:0] {
        PACE_STEADY,
        PACE_SRC_GAPS,
        PACE_SNK_STALLS,
        PACE_BOTH
    } t_pace;

    // one input word as the sender offers it
    typedef struct {
        logic               kind;
        logic [ENTRY_W-1:0] entry_index;
        logic [MASK_W-1:0]  left_mask;
        logic [MASK_W-1:0]  right_mask;
        logic [MASK_W-1:0]  start_mask;
    } t_dep_word;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [FDC_W-1:0]  i_cfg_data;

    ace_in_if  dep_in ();
    ace_out_if closure_out ();

    attribute_closure_engine_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (dep_in),
        .o_out      (closure_out)
    );

    // predictor state: dependency table and entries in use
    logic [MASK_W-1:0] left_tab  [MAX_FDS];
    logic [MASK_W-1:0] right_tab [MAX_FDS];
    logic [FDC_W-1:0]  fd_in_use;

    t_dep_word         pending_words[$];
    logic [MASK_W-1:0] closure_expect_q[$];

    t_pace             pace_mode;
    logic              word_taken;
    logic              hold_off_armed;
    logic              hold_off_done;
    int                hold_off_count;
    int                idle_cycles;
    int                mismatches;
    logic [4:0]        attr_pool [POOL_SIZE];

    logic [FDC_W-1:0]  phase_count [RANDOM_PHASES] =
        '{5'd16, 5'd3, 5'd31, 5'd0, 5'd8, 5'd17, 5'd1, 5'd16};

    // closure of a start set: repeat passes in index order until one adds nothing
    function automatic logic [MASK_W-1:0] expand_closure(logic [MASK_W-1:0] start);
        logic [MASK_W-1:0] set;
        logic              grew;
        int                used;
        set  = start & ATTR_MASK;
        used = (fd_in_use > MAX_FDS) ? MAX_FDS : int'(fd_in_use);
        grew = 1'b1;
        while (grew) begin
            grew = 1'b0;
            for (int i = 0; i < used; i++) begin
                if ((left_tab[i] & ~set) == '0 && (set | right_tab[i]) != set) begin
                    set  = set | right_tab[i];
                    grew = 1'b1;
                end
            end
        end
        return set;
    endfunction

    // a few attributes drawn from the phase's small pool, so chains form often
    function automatic logic [MASK_W-1:0] pool_bits(int n);
        logic [MASK_W-1:0] m;
        m = '0;
        for (int i = 0; i < n; i++)
            m[attr_pool[$urandom_range(POOL_SIZE-1)]] = 1'b1;
        return m;
    endfunction

    function automatic t_dep_word random_word();
        t_dep_word w;
        w.kind        = ($urandom_range(99) < 45) ? KIND_LOAD : KIND_QUERY;
        w.entry_index = ENTRY_W'($urandom_range(MAX_FDS-1));
        w.left_mask   = pool_bits(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 2));
        w.right_mask  = pool_bits($urandom_range(1, 3));
        w.start_mask  = pool_bits($urandom_range(1, 2));
        if ($urandom_range(3) == 0)
            w.start_mask = w.start_mask | $urandom;
        // plain noise now and then, so every bit of every field toggles
        if ($urandom_range(9) == 0) begin
            w.kind       = 1'($urandom_range(1));
            w.left_mask  = $urandom;
            w.right_mask = $urandom;
            w.start_mask = $urandom;
        end
        return w;
    endfunction

    function automatic bit sender_rests();
        case (pace_mode)
            PACE_SRC_GAPS: return $urandom_range(99) < 54;
            PACE_BOTH:     return $urandom_range(99) < 20;
            default:       return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (pace_mode)
            PACE_SNK_STALLS: return $urandom_range(99) < 54;
            PACE_BOTH:       return $urandom_range(99) < 20;
            default:         return 1'b0;
        endcase
    endfunction

    // append one word to the pending queue
    task automatic append_word(t_dep_word w);
        pending_words = {pending_words, w};
    endtask

    task automatic queue_load(int idx, logic [MASK_W-1:0] lm, logic [MASK_W-1:0] rm);
        t_dep_word w;
        w.kind        = KIND_LOAD;
        w.entry_index = ENTRY_W'(idx);
        w.left_mask   = lm;
        w.right_mask  = rm;
        w.start_mask  = $urandom;
        append_word(w);
    endtask

    task automatic queue_query(logic [MASK_W-1:0] sm);
        t_dep_word w;
        w.kind        = KIND_QUERY;
        w.entry_index = ENTRY_W'($urandom_range(MAX_FDS-1));
        w.left_mask   = $urandom;
        w.right_mask  = $urandom;
        w.start_mask  = sm;
        append_word(w);
    endtask

    // wait until every word is taken and every closure returned, then let the engine settle
    task automatic drain_and_rest();
        while (pending_words.size() != 0 || dep_in.valid || closure_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write while the engine is idle
    task automatic set_fd_count(logic [FDC_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        fd_in_use = value;
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // sender: offer the next word when the bus is free or the last word was taken
    always @(negedge i_clk) begin
        if (i_rst_n && (!dep_in.valid || word_taken)) begin
            if (pending_words.size() != 0 && !sender_rests()) begin
                dep_in.valid       <= 1'b1;
                dep_in.kind        <= pending_words[0].kind;
                dep_in.entry_index <= pending_words[0].entry_index;
                dep_in.left_mask   <= pending_words[0].left_mask;
                dep_in.right_mask  <= pending_words[0].right_mask;
                dep_in.start_mask  <= pending_words[0].start_mask;
                void'(pending_words.pop_front());
            end else begin
                dep_in.valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off that fills the engine
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            closure_out.ready <= 1'b0;
        end else if (hold_off_armed && !hold_off_done) begin
            closure_out.ready <= 1'b0;
            hold_off_count = hold_off_count + 1;
            if (hold_off_count >= HOLD_OFF_CYCLES)
                hold_off_done = 1'b1;
        end else begin
            closure_out.ready <= !receiver_stalls();
        end
    end

    // predictor update, closure check and watchdog at the sampling edge
    always @(posedge i_clk) begin
        word_taken <= dep_in.valid && dep_in.ready;
        if (i_rst_n) begin
            if (dep_in.valid && dep_in.ready) begin
                if (dep_in.kind == KIND_LOAD) begin
                    left_tab[dep_in.entry_index]  = dep_in.left_mask & ATTR_MASK;
                    right_tab[dep_in.entry_index] = dep_in.right_mask & ATTR_MASK;
                end else begin
                    closure_expect_q = {closure_expect_q,
                                        expand_closure(dep_in.start_mask)};
                end
            end
            if (closure_out.valid && closure_out.ready) begin
                if (closure_expect_q.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected closure word %h", closure_out.closure_mask);
                end else begin
                    if (closure_out.closure_mask !== closure_expect_q[0]) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= MAX_REPORTS)
                            $display("closure_mask mismatch: expected %h actual %h",
                                     closure_expect_q[0], closure_out.closure_mask);
                    end
                    void'(closure_expect_q.pop_front());
                end
            end
            // nothing moving on either channel for too long means a hang
            if ((dep_in.valid && dep_in.ready) || (closure_out.valid && closure_out.ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired after %0d idle cycles", idle_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        logic [FDC_W-1:0] count;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_data         = '0;
        dep_in.valid       = 1'b0;
        dep_in.kind        = KIND_LOAD;
        dep_in.entry_index = '0;
        dep_in.left_mask   = '0;
        dep_in.right_mask  = '0;
        dep_in.start_mask  = '0;
        closure_out.ready  = 1'b0;
        word_taken         = 1'b0;
        hold_off_armed     = 1'b0;
        hold_off_done      = 1'b0;
        hold_off_count     = 0;
        idle_cycles        = 0;
        mismatches         = 0;
        fd_in_use          = '0;
        pace_mode          = PACE_STEADY;
        for (int i = 0; i < MAX_FDS; i++) begin
            left_tab[i]  = '0;
            right_tab[i] = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++)
            attr_pool[i] = 5'(i);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // no entries in use: closure is the start set itself
        queue_query('1);
        queue_query('0);
        drain_and_rest();

        // reversed chain: each pass adds only one attribute, so passes hit their maximum
        for (int i = 0; i < MAX_FDS; i++)
            queue_load(i, 32'd1 << (15 - i), 32'd1 << (16 - i));
        drain_and_rest();
        set_fd_count(FDC_W'(16));
        queue_query(32'h1);
        queue_query('0);
        drain_and_rest();

        // count above the table size acts as the full table
        set_fd_count(FDC_W'(31));
        queue_query(32'h1);

        // empty determinant always fires; full determinant needs every attribute
        queue_load(3, '0, 32'h8000_0000);
        queue_load(5, '1, '1);
        queue_query(32'h7fff_ffff);
        queue_query('0);
        drain_and_rest();

        // random phases over counts and handshake pacing
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            count = (ph == 6) ? FDC_W'($urandom_range(31)) : phase_count[ph];
            set_fd_count(count);
            pace_mode = t_pace'(ph % 4);
            for (int i = 0; i < POOL_SIZE; i++)
                attr_pool[i] = (ph % 4 == 0) ? 5'(ph * 2 + i * 4) : 5'($urandom_range(31));
            if (ph == 4)
                hold_off_armed = 1'b1;
            for (int i = 0; i < PHASE_WORDS; i++)
                append_word(random_word());
            drain_and_rest();
        end

        if (mismatches == 0 && closure_expect_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
